// ===== sv/vmt_pkg.sv =====
package vmt_pkg;

    // Table geometry
    localparam int VMT_DEPTH = 16;
    localparam int VMT_IDX_W = (VMT_DEPTH > 1) ? $clog2(VMT_DEPTH) : 1;
    localparam int VMT_CNT_W = $clog2(VMT_DEPTH + 1);
    localparam int VMT_CAP_W = 5;
    localparam int VMT_LIM_W = ((VMT_CNT_W > VMT_CAP_W) ? VMT_CNT_W : VMT_CAP_W) + 1;
    localparam int VMT_WORD_W = 64;
    localparam int VMT_OUT_CNT_W = 5;

    // Stream widths
    localparam int VMT_IN_TDATA_W = 128;
    localparam int VMT_OUT_TDATA_W = 264;
    localparam int VMT_OUT_PACK_W = 4 * VMT_WORD_W + VMT_OUT_CNT_W;

    typedef logic [VMT_WORD_W-1:0] t_word;

    typedef enum logic {
        OP_JOIN  = 1'b0,
        OP_LEAVE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_APPLIED = 3'd0,
        ST_STALE   = 3'd1,
        ST_ALREADY = 3'd2,
        ST_FULL    = 3'd3,
        ST_MISSING = 3'd4,
        ST_INVALID = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_GROUP    = 1'b1
    } t_reg;

    // Classified request, front to back
    typedef struct packed {
        t_op   op;
        t_word id;
        t_word epoch;
        logic  invalid;
    } t_req;

    // One result word, back to top
    typedef struct packed {
        t_status                  status;
        t_word                    group;
        t_word                    subject;
        t_word                    rep;
        logic [VMT_OUT_CNT_W-1:0] count;
        t_word                    listed;
        logic                     last;
    } t_res;

endpackage

// ===== sv/vmt_front.sv =====
module vmt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vmt_pkg::t_op  i_op,
    input  vmt_pkg::t_word i_id,
    input  vmt_pkg::t_word i_epoch,
    output logic          o_req_valid,
    input  logic          i_req_ready,
    output vmt_pkg::t_req o_req
);

    // Two-word queue decoupling intake from the table engine
    vmt_pkg::t_req r_q [2];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;
    logic          push, pop;
    vmt_pkg::t_req in_req;

    // Classify: zero id or zero epoch is flagged here
    always_comb begin
        in_req.op      = i_op;
        in_req.id      = i_id;
        in_req.epoch   = i_epoch;
        in_req.invalid = (i_id == '0) || (i_epoch == '0);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_req_valid && i_req_ready;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_req;
        end
    end

endmodule

// ===== sv/vmt_table.sv =====
module vmt_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  vmt_pkg::t_req                   i_req,
    input  logic [vmt_pkg::VMT_CAP_W-1:0]   i_cap,
    input  vmt_pkg::t_word                  i_group,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output vmt_pkg::t_res                   o_res
);

    // Members are kept sorted by id in slots 0..count-1
    vmt_pkg::t_word                  r_ids [vmt_pkg::VMT_DEPTH];
    vmt_pkg::t_word                  r_eps [vmt_pkg::VMT_DEPTH];
    logic [vmt_pkg::VMT_CNT_W-1:0]   r_count;
    vmt_pkg::t_state                 r_state, n_state;
    vmt_pkg::t_req                   r_req;
    logic [vmt_pkg::VMT_DEPTH-1:0]   r_eq;
    logic [vmt_pkg::VMT_DEPTH-1:0]   r_lt;
    vmt_pkg::t_status                r_status, n_status;
    vmt_pkg::t_word                  r_rep, n_rep;
    logic [vmt_pkg::VMT_IDX_W-1:0]   r_idx;
    logic                            r_out_valid;
    vmt_pkg::t_res                   r_out;

    logic [vmt_pkg::VMT_DEPTH-1:0]   ge;
    vmt_pkg::t_word                  ep_hit;
    logic                            hit;
    logic                            full;
    logic [vmt_pkg::VMT_LIM_W-1:0]   lim;
    logic                            do_upd, do_ins, do_rem;
    logic                            load;
    logic                            last_n;
    logic                            take;

    // Hit decode: epoch of the matching slot and prefix of the match
    always_comb begin
        ep_hit = '0;
        for (int i = 0; i < vmt_pkg::VMT_DEPTH; i++) begin
            ep_hit = ep_hit | (r_eps[i] & {vmt_pkg::VMT_WORD_W{r_eq[i]}});
        end
        ge[0] = r_eq[0];
        for (int i = 1; i < vmt_pkg::VMT_DEPTH; i++) begin
            ge[i] = ge[i-1] | r_eq[i];
        end
        hit = |r_eq;
        lim = (vmt_pkg::VMT_LIM_W'(i_cap) > vmt_pkg::VMT_LIM_W'(vmt_pkg::VMT_DEPTH))
            ? vmt_pkg::VMT_LIM_W'(vmt_pkg::VMT_DEPTH) : vmt_pkg::VMT_LIM_W'(i_cap);
        full = (vmt_pkg::VMT_LIM_W'(r_count) >= lim);
    end

    // Request decision
    always_comb begin
        n_status = vmt_pkg::ST_APPLIED;
        n_rep    = r_req.epoch;
        do_upd   = 1'b0;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        if (r_req.invalid) begin
            n_status = vmt_pkg::ST_INVALID;
        end else if (r_req.op == vmt_pkg::OP_JOIN) begin
            if (hit) begin
                if (r_req.epoch < ep_hit) begin
                    n_status = vmt_pkg::ST_STALE;
                    n_rep    = ep_hit;
                end else if (r_req.epoch == ep_hit) begin
                    n_status = vmt_pkg::ST_ALREADY;
                end else begin
                    do_upd = 1'b1;
                end
            end else if (full) begin
                n_status = vmt_pkg::ST_FULL;
            end else begin
                do_ins = 1'b1;
            end
        end else begin
            if (!hit) begin
                n_status = vmt_pkg::ST_MISSING;
            end else if (r_req.epoch != ep_hit) begin
                n_status = vmt_pkg::ST_STALE;
                n_rep    = ep_hit;
            end else begin
                do_rem = 1'b1;
            end
        end
    end

    assign take   = r_out_valid && i_res_ready;
    assign load   = (r_state == vmt_pkg::S_EMIT) && (!r_out_valid || i_res_ready);
    assign last_n = ((vmt_pkg::VMT_CNT_W'(r_idx) + vmt_pkg::VMT_CNT_W'(1)) >= r_count);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        case (r_state)
            vmt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = vmt_pkg::S_LOOK;
                end
            end
            vmt_pkg::S_LOOK: begin
                n_state = vmt_pkg::S_EXEC;
            end
            vmt_pkg::S_EXEC: begin
                n_state = vmt_pkg::S_EMIT;
            end
            vmt_pkg::S_EMIT: begin
                if (load && last_n) begin
                    n_state = vmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == vmt_pkg::S_EXEC) begin
                if (do_ins) begin
                    r_count <= r_count + vmt_pkg::VMT_CNT_W'(1);
                end else if (do_rem) begin
                    r_count <= r_count - vmt_pkg::VMT_CNT_W'(1);
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Lookup, table update and list emission
    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (r_state == vmt_pkg::S_LOOK) begin
            for (int i = 0; i < vmt_pkg::VMT_DEPTH; i++) begin
                r_eq[i] <= (vmt_pkg::VMT_CNT_W'(i) < r_count) && (r_ids[i] == r_req.id);
                r_lt[i] <= (vmt_pkg::VMT_CNT_W'(i) < r_count) && (r_ids[i] < r_req.id);
            end
        end
        if (r_state == vmt_pkg::S_EXEC) begin
            r_status <= n_status;
            r_rep    <= n_rep;
            r_idx    <= '0;
            if (do_upd) begin
                for (int i = 0; i < vmt_pkg::VMT_DEPTH; i++) begin
                    if (r_eq[i]) begin
                        r_eps[i] <= r_req.epoch;
                    end
                end
            end
            if (do_rem) begin
                for (int i = 0; i < vmt_pkg::VMT_DEPTH - 1; i++) begin
                    if (ge[i]) begin
                        r_ids[i] <= r_ids[i+1];
                        r_eps[i] <= r_eps[i+1];
                    end
                end
            end
            if (do_ins) begin
                // open a gap at the first slot not below the new id
                if (!r_lt[0]) begin
                    r_ids[0] <= r_req.id;
                    r_eps[0] <= r_req.epoch;
                end
                for (int i = 1; i < vmt_pkg::VMT_DEPTH; i++) begin
                    if (!r_lt[i]) begin
                        if (r_lt[i-1]) begin
                            r_ids[i] <= r_req.id;
                            r_eps[i] <= r_req.epoch;
                        end else begin
                            r_ids[i] <= r_ids[i-1];
                            r_eps[i] <= r_eps[i-1];
                        end
                    end
                end
            end
        end
        if (load) begin
            r_out.status  <= r_status;
            r_out.group   <= i_group;
            r_out.subject <= r_req.id;
            r_out.rep     <= r_rep;
            r_out.count   <= vmt_pkg::VMT_OUT_CNT_W'(r_count);
            r_out.listed  <= (r_count == '0) ? '0 : r_ids[r_idx];
            r_out.last    <= last_n;
            r_idx         <= r_idx + vmt_pkg::VMT_IDX_W'(1);
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vmt_pkg::VMT_LIM_W'(r_count) <= vmt_pkg::VMT_LIM_W'(vmt_pkg::VMT_DEPTH))
        else $error("member count above table depth");

    a_count_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != vmt_pkg::S_EXEC) |=> $stable(r_count))
        else $error("member count changed outside execute");

    a_invalid_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vmt_pkg::S_EXEC && r_req.invalid) |=> $stable(r_count))
        else $error("invalid request changed the table");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && last_n) |=> (r_state == vmt_pkg::S_IDLE))
        else $error("run did not end after last word");

endmodule

// ===== sv/versioned_membership_table_top.sv =====
// Versioned membership table.
// Input stream (s_axis): one request word per handshake. tdata carries the
// member id and the request epoch, tuser the request kind (join or leave).
// Output stream (m_axis): each request yields a run of result words, one per
// current member in ascending id order (a single word when the table is
// empty), the final word flagged by tlast. Every word repeats the status,
// group id, echoed id, reported epoch and member count.
// The engine takes a request from the intake queue, registers the match
// vectors in lookup, updates the table in execute and registers each result
// word in emit; then one word per cycle while m_axis_tready is high.
// The lookup, execute and one-slot-per-cycle list readout of the table engine
// set the pace; the engine takes the next request once a run's last word is loaded.
// A two-word intake queue takes up to two more requests while a run is emitted.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 capacity limit, 1 group id); write only while the block is idle.
// Reset (synchronous, active low) empties the table, the queue and the output
// register, and sets capacity 16 and group id 1.
// A stalled receiver holds the current output word; the engine waits on it,
// and the intake queue fills and then drops s_axis_tready.
module versioned_membership_table_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [63:0] member_id, [127:64] epoch
    input  logic [vmt_pkg::VMT_IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] op
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [63:0] group_echo, [127:64] subject_id, [191:128] reported_epoch,
    // [196:192] member_count, [260:197] listed_member, [263:261] zero
    output logic [vmt_pkg::VMT_OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]                            o_m_axis_tuser,
    output logic                                  o_m_axis_tlast,
    input  logic                                  i_cfg_wr_en,
    input  logic                                  i_cfg_index,
    input  logic [vmt_pkg::VMT_WORD_W-1:0]        i_cfg_data
);

    logic [vmt_pkg::VMT_CAP_W-1:0] r_cap;
    vmt_pkg::t_word                r_group;
    logic                          req_valid, req_ready;
    vmt_pkg::t_req                 req;
    vmt_pkg::t_res                 res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= vmt_pkg::VMT_CAP_W'(16);
            r_group <= vmt_pkg::VMT_WORD_W'(1);
        end else if (i_cfg_wr_en) begin
            case (vmt_pkg::t_reg'(i_cfg_index))
                vmt_pkg::REG_CAPACITY: r_cap   <= i_cfg_data[vmt_pkg::VMT_CAP_W-1:0];
                vmt_pkg::REG_GROUP:    r_group <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (vmt_pkg::t_op'(i_s_axis_tuser)),
        .i_id        (i_s_axis_tdata[63:0]),
        .i_epoch     (i_s_axis_tdata[127:64]),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready),
        .o_req       (req)
    );

    vmt_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .i_cap       (r_cap),
        .i_group     (r_group),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    // Pack result word
    assign o_m_axis_tdata = {
        {(vmt_pkg::VMT_OUT_TDATA_W - vmt_pkg::VMT_OUT_PACK_W){1'b0}},
        res.listed, res.count, res.rep, res.subject, res.group
    };
    assign o_m_axis_tuser = res.status;
    assign o_m_axis_tlast = res.last;

endmodule

// ===== bench/versioned_membership_table_top_tb.sv =====
module versioned_membership_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int POOL_N         = 24;
    localparam vmt_pkg::t_word WORD_MAX = {vmt_pkg::VMT_WORD_W{1'b1}};
    localparam int NO_TYPED       = -1;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_valid = 1'b0;
    logic [vmt_pkg::VMT_IN_TDATA_W-1:0]  s_data = '0;
    logic                                s_user = 1'b0;
    logic                                m_ready = 1'b0;
    logic                                cfg_we = 1'b0;
    logic                                cfg_idx = 1'b0;
    logic [vmt_pkg::VMT_WORD_W-1:0]      cfg_data = '0;
    logic                                s_ready;
    logic                                m_valid;
    logic [vmt_pkg::VMT_OUT_TDATA_W-1:0] m_data;
    logic [2:0]                          m_user;
    logic                                m_last;

    versioned_membership_table_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow table, mirrors the block
    vmt_pkg::t_word tbl_id [vmt_pkg::VMT_DEPTH];
    vmt_pkg::t_word tbl_ep [vmt_pkg::VMT_DEPTH];
    bit             tbl_vld[vmt_pkg::VMT_DEPTH];
    int             cap_lim = 16;
    vmt_pkg::t_word grp_id = 1;

    vmt_pkg::t_res  expected_words[$];
    int             typed_status[$];
    int             mismatches = 0;
    int             n_req = 0;
    int             n_words = 0;
    int             n_cfg = 0;
    int             status_seen[6];
    bit             idle_on = 1'b1;
    bit             long_hold = 1'b0;
    int             quiet_cycles = 0;

    // Apply one request to the shadow table and queue its listing run
    function automatic void apply_request(vmt_pkg::t_op op, vmt_pkg::t_word id,
                                          vmt_pkg::t_word ep, int typed);
        vmt_pkg::t_status st;
        vmt_pkg::t_word   rep = ep;
        int               slot = -1;
        int               fslot = -1;
        int               cnt = 0;
        int               lim;
        int               n = 0;
        vmt_pkg::t_word   prev = 0;
        vmt_pkg::t_word   best;
        bit               found;
        vmt_pkg::t_res    r;
        lim = (cap_lim > vmt_pkg::VMT_DEPTH) ? vmt_pkg::VMT_DEPTH : cap_lim;
        for (int i = 0; i < vmt_pkg::VMT_DEPTH; i++) begin
            if (tbl_vld[i] && tbl_id[i] == id && slot < 0) slot = i;
            if (!tbl_vld[i] && fslot < 0) fslot = i;
            if (tbl_vld[i]) cnt++;
        end
        if (id == 0 || ep == 0) begin
            st = vmt_pkg::ST_INVALID;
        end else if (op == vmt_pkg::OP_JOIN) begin
            if (slot >= 0) begin
                if (ep < tbl_ep[slot]) begin
                    st = vmt_pkg::ST_STALE;
                    rep = tbl_ep[slot];
                end else if (ep == tbl_ep[slot]) begin
                    st = vmt_pkg::ST_ALREADY;
                end else begin
                    tbl_ep[slot] = ep;
                    st = vmt_pkg::ST_APPLIED;
                end
            end else if (cnt >= lim || fslot < 0) begin
                st = vmt_pkg::ST_FULL;
            end else begin
                tbl_id[fslot] = id;
                tbl_ep[fslot] = ep;
                tbl_vld[fslot] = 1'b1;
                st = vmt_pkg::ST_APPLIED;
            end
        end else begin
            if (slot < 0) begin
                st = vmt_pkg::ST_MISSING;
            end else if (ep != tbl_ep[slot]) begin
                st = vmt_pkg::ST_STALE;
                rep = tbl_ep[slot];
            end else begin
                tbl_vld[slot] = 1'b0;
                st = vmt_pkg::ST_APPLIED;
            end
        end
        if (typed != NO_TYPED) st = vmt_pkg::t_status'(typed);
        status_seen[st]++;
        cnt = 0;
        foreach (tbl_vld[i]) if (tbl_vld[i]) cnt++;
        // ascending walk: next larger id per word
        do begin
            best = 0;
            found = 1'b0;
            for (int i = 0; i < vmt_pkg::VMT_DEPTH; i++)
                if (tbl_vld[i] && tbl_id[i] > prev && (!found || tbl_id[i] < best)) begin
                    best = tbl_id[i];
                    found = 1'b1;
                end
            r.status  = st;
            r.group   = grp_id;
            r.subject = id;
            r.rep     = rep;
            r.count   = cnt[vmt_pkg::VMT_OUT_CNT_W-1:0];
            r.listed  = found ? best : '0;
            r.last    = 1'b0;
            prev = best;
            n++;
            if (!(n < cnt && n < vmt_pkg::VMT_DEPTH)) r.last = 1'b1;
            expected_words.insert(expected_words.size(), r);
        end while (n < cnt && n < vmt_pkg::VMT_DEPTH);
    endfunction

    // Input and output monitors, checker, watchdog
    always @(posedge i_clk) begin
        vmt_pkg::t_res e;
        vmt_pkg::t_res a;
        if (i_rst_n && s_valid && s_ready) begin
            n_req++;
            apply_request(vmt_pkg::t_op'(s_user), s_data[63:0], s_data[127:64],
                          typed_status.pop_front());
        end
        if (i_rst_n && m_valid && m_ready) begin
            n_words++;
            a.status  = vmt_pkg::t_status'(m_user);
            a.group   = m_data[63:0];
            a.subject = m_data[127:64];
            a.rep     = m_data[191:128];
            a.count   = m_data[196:192];
            a.listed  = m_data[260:197];
            a.last    = m_last;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t: unexpected result word %p", $realtime, a);
            end else begin
                e = expected_words.pop_front();
                if (e.status !== a.status || e.group !== a.group ||
                    e.subject !== a.subject || e.rep !== a.rep ||
                    e.count !== a.count || e.listed !== a.listed || e.last !== a.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, e, a);
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk iff m_valid);
        end
    end

    task automatic send_word(vmt_pkg::t_op op, vmt_pkg::t_word id, vmt_pkg::t_word ep,
                             int typed);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_status.insert(typed_status.size(), typed);
        s_valid <= 1'b1;
        s_data  <= {ep, id};
        s_user  <= op;
        @(posedge i_clk iff s_ready);
    endtask

    // Drain everything, let the engine settle, then write both registers
    task automatic write_regs(int cap, vmt_pkg::t_word grp);
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_words.size() == 0);
        repeat (8) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= vmt_pkg::REG_CAPACITY;
        cfg_data <= vmt_pkg::t_word'(cap);
        @(posedge i_clk);
        cfg_idx  <= vmt_pkg::REG_GROUP;
        cfg_data <= grp;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cap_lim = cap & 5'h1f;
        grp_id  = grp;
        n_cfg++;
    endtask

    typedef struct {
        bit             is_cfg;
        vmt_pkg::t_op   op;
        vmt_pkg::t_word a;
        vmt_pkg::t_word b;
        int             typed;
    } t_row;

    // Directed: statuses from reset, extremes, capacity zero and lowered limit
    t_row directed[] = '{
        '{0, vmt_pkg::OP_LEAVE, 5,        1,        vmt_pkg::ST_MISSING},
        '{0, vmt_pkg::OP_JOIN,  0,        1,        vmt_pkg::ST_INVALID},
        '{0, vmt_pkg::OP_JOIN,  5,        0,        vmt_pkg::ST_INVALID},
        '{0, vmt_pkg::OP_LEAVE, 0,        0,        vmt_pkg::ST_INVALID},
        '{0, vmt_pkg::OP_JOIN,  5,        10,       vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_JOIN,  5,        10,       vmt_pkg::ST_ALREADY},
        '{0, vmt_pkg::OP_JOIN,  5,        3,        NO_TYPED},
        '{0, vmt_pkg::OP_JOIN,  5,        WORD_MAX, vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_LEAVE, 5,        7,        NO_TYPED},
        '{0, vmt_pkg::OP_JOIN,  WORD_MAX, WORD_MAX, vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_JOIN,  1,        1,        vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_LEAVE, 5,        WORD_MAX, vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_LEAVE, WORD_MAX, WORD_MAX, vmt_pkg::ST_APPLIED},
        '{1, vmt_pkg::OP_JOIN,  0,        0,        NO_TYPED},
        '{0, vmt_pkg::OP_JOIN,  9,        1,        vmt_pkg::ST_FULL},
        '{0, vmt_pkg::OP_JOIN,  1,        2,        vmt_pkg::ST_APPLIED},
        '{1, vmt_pkg::OP_JOIN,  2,        WORD_MAX, NO_TYPED},
        '{0, vmt_pkg::OP_JOIN,  7,        1,        vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_JOIN,  8,        1,        vmt_pkg::ST_FULL},
        '{0, vmt_pkg::OP_LEAVE, 7,        1,        vmt_pkg::ST_APPLIED},
        '{0, vmt_pkg::OP_JOIN,  8,        4,        vmt_pkg::ST_APPLIED}
    };

    initial begin
        vmt_pkg::t_word pool_id[POOL_N];
        vmt_pkg::t_word pool_ep[POOL_N];
        int             caps[6];
        int             k;
        vmt_pkg::t_op   op;
        vmt_pkg::t_word ep;
        caps = '{31, 1, 16, 8, 0, 16};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) write_regs(int'(directed[i].a), directed[i].b);
            else send_word(directed[i].op, directed[i].a, directed[i].b, directed[i].typed);
        end

        // Random phases, one register setting each
        for (int ph = 0; ph < 6; ph++) begin
            write_regs(caps[ph], (ph == 2) ? WORD_MAX : {$urandom, $urandom});
            idle_on = (ph != 3);
            foreach (pool_id[i]) begin
                pool_id[i] = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                         : $urandom_range(1, 40);
                pool_ep[i] = 1;
            end
            for (int n = 0; n < 75; n++) begin
                if (ph == 1 && n == 10) long_hold = 1'b1;
                k  = $urandom_range(0, POOL_N - 1);
                op = ($urandom_range(0, 99) < 65) ? vmt_pkg::OP_JOIN : vmt_pkg::OP_LEAVE;
                case ($urandom_range(0, 19))
                    0:       ep = 0;
                    1:       ep = WORD_MAX;
                    2, 3:    ep = {$urandom, $urandom};
                    default: ep = (op == vmt_pkg::OP_LEAVE && $urandom_range(0, 2) != 0)
                                  ? pool_ep[k] : $urandom_range(1, 8);
                endcase
                if (op == vmt_pkg::OP_JOIN && ep != 0) pool_ep[k] = ep;
                send_word(op, ($urandom_range(0, 40) == 0) ? 0 : pool_id[k], ep, NO_TYPED);
            end
        end

        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_words.size() == 0);
        repeat (30) @(posedge i_clk);
        $display("covered %0d requests, %0d result words, %0d register settings",
                 n_req, n_words, n_cfg);
        $display("status mix applied/stale/already/full/missing/invalid: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/vmt_pkg.sv
sv/vmt_front.sv
sv/vmt_table.sv
sv/versioned_membership_table_top.sv
bench/versioned_membership_table_top_tb.sv
